[rtl/cobs_pkg.sv]
// ----------------------------------------------------------------------------
// cobs_pkg: shared types and constants of the COBS encoder
// Transfer payload structs and encoder limits.
// ----------------------------------------------------------------------------
package cobs_pkg;

  localparam int unsigned IDX_W_DEF = 16;   // default slot counter width
  localparam int unsigned CAP_W     = 16;   // capacity register width
  localparam int unsigned POS_W     = 16;   // buffer position field width
  localparam int unsigned MAX_RES   = 3;    // results one input item can cause

  localparam logic [7:0]  RUN_FULL  = 8'd255;   // code byte of a full run (254 + 1)
  localparam logic [CAP_W-1:0] CAP_RESET = 16'hFFFF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       empty_frame;
    logic       last;
  } cobs_in_t;

  typedef struct packed {
    logic             write_valid;
    logic [POS_W-1:0] write_index;
    logic [7:0]       write_byte;
    logic             is_code;
    logic             frame_end;
    logic             error;
    logic [POS_W-1:0] encoded_length;
    logic             last_of_input;
  } cobs_out_t;

endpackage

[rtl/cobs_byte_stuffing_encoder_unit.sv]
// ----------------------------------------------------------------------------
// cobs_byte_stuffing_encoder_unit: COBS encoder, one raw byte per transfer
// Turns a byte stream into write commands for an output buffer.
// ----------------------------------------------------------------------------
// Usage:
//  - in_*  : valid/ready channel, one raw byte per transfer with last and
//            empty_frame flags (empty_frame ends the frame without a byte).
//  - out_* : valid/ready channel of buffer write commands. Data bytes go to
//            the next slot, code bytes are backfilled into their reserved slot
//            (is_code), the frame end carries the final code and the encoded
//            length, or error when out_capacity was exceeded.
//  - cfg_* : write enable and data for out_capacity; write only when idle.
// Latency: results of an accepted item appear on out_* the next cycle.
// Throughput: one item per cycle while out_ready is high and each item yields
//   at most one result. An item that yields k results (k up to 3: data write,
//   full-run code, frame end) fills the 3-entry result queue; drain sets the rate.
// Reset (rst_n low, synchronous): no frame open, queue empty, capacity 65535.
// Receiver stall: the head result holds on out_data; in_ready drops once the
//   queue cannot be emptied this cycle, so nothing is lost.
// ----------------------------------------------------------------------------
module cobs_byte_stuffing_encoder_unit
  import cobs_pkg::*;
#(
  parameter int unsigned INDEX_WIDTH = IDX_W_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                in_valid,
  output logic                in_ready,
  input  cobs_in_t            in_data,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output cobs_out_t           out_data,
  // configuration
  input  logic                cfg_wr_en,
  input  logic [CAP_W-1:0]    cfg_wr_data
);

  // compare width covering both slot counter and capacity
  localparam int unsigned CMP_W = (INDEX_WIDTH > CAP_W) ? INDEX_WIDTH : CAP_W;
  localparam int unsigned CNT_W = $clog2(MAX_RES + 1);
  localparam int unsigned QIX_W = $clog2(MAX_RES);

  // encoder state
  logic [CAP_W-1:0]       cap_r;
  logic [INDEX_WIDTH-1:0] code_slot_r, code_slot_nxt;
  logic [INDEX_WIDTH-1:0] next_slot_r, next_slot_nxt;
  logic [7:0]             run_code_r, run_code_nxt;
  logic                   failed_r, failed_nxt;
  logic                   open_r, open_nxt;

  // result queue, head at entry 0
  cobs_out_t              q_r   [MAX_RES];
  cobs_out_t              res   [MAX_RES];
  logic [CNT_W-1:0]       q_cnt_r;
  logic [CNT_W-1:0]       res_cnt;

  logic in_fire, out_fire;

  function automatic logic fits(input logic [INDEX_WIDTH-1:0] slot,
                                input logic [CAP_W-1:0] cap);
    return CMP_W'(slot) < CMP_W'(cap);
  endfunction

  function automatic cobs_out_t make_res(input logic                   vld,
                                         input logic [INDEX_WIDTH-1:0] idx,
                                         input logic [7:0]             byt,
                                         input logic                   code,
                                         input logic                   fend,
                                         input logic                   err,
                                         input logic [INDEX_WIDTH-1:0] len);
    cobs_out_t r;
    r.write_valid    = vld;
    r.write_index    = POS_W'(idx);
    r.write_byte     = byt;
    r.is_code        = code;
    r.frame_end      = fend;
    r.error          = err;
    r.encoded_length = POS_W'(len);
    r.last_of_input  = 1'b0;
    return r;
  endfunction

  assign out_valid = (q_cnt_r != '0);
  assign out_data  = q_r[0];
  assign out_fire  = out_valid && out_ready;
  // queue drains this cycle when at most its head is left and it is taken
  assign in_ready  = (q_cnt_r == '0) || ((q_cnt_r == CNT_W'(1)) && out_ready);
  assign in_fire   = in_valid && in_ready;

  // --------------------------------------------------------------------------
  // Single-pass encode of one item: up to three results plus next state
  // --------------------------------------------------------------------------
  always_comb begin
    logic [INDEX_WIDTH-1:0] ns1;
    logic [7:0]             rc1;
    logic                   frame_done;
    code_slot_nxt = code_slot_r;
    next_slot_nxt = next_slot_r;
    run_code_nxt  = run_code_r;
    failed_nxt    = failed_r;
    open_nxt      = open_r;
    res_cnt       = '0;
    ns1           = '0;
    rc1           = '0;
    frame_done    = in_data.empty_frame || in_data.last;
    for (int i = 0; i < MAX_RES; i++) begin
      res[i] = '0;
    end

    // frame start
    if (!open_r) begin
      code_slot_nxt = '0;
      next_slot_nxt = INDEX_WIDTH'(1);
      run_code_nxt  = 8'd1;
      failed_nxt    = (cap_r == '0);
      open_nxt      = 1'b1;
    end

    if (!in_data.empty_frame && !failed_nxt) begin
      priority if (in_data.data_byte == 8'd0) begin
        // zero byte closes the run: backfill its code, reserve a fresh slot
        res[QIX_W'(res_cnt)] = make_res(1'b1, code_slot_nxt, run_code_nxt,
                                        1'b1, 1'b0, 1'b0, '0);
        res_cnt = res_cnt + CNT_W'(1);
        if (fits(next_slot_nxt, cap_r)) begin
          code_slot_nxt = next_slot_nxt;
          next_slot_nxt = next_slot_nxt + INDEX_WIDTH'(1);
          run_code_nxt  = 8'd1;
        end else begin
          failed_nxt = 1'b1;
        end
      end else if (!fits(next_slot_nxt, cap_r)) begin
        failed_nxt = 1'b1;
      end else begin
        res[QIX_W'(res_cnt)] = make_res(1'b1, next_slot_nxt, in_data.data_byte,
                                        1'b0, 1'b0, 1'b0, '0);
        res_cnt = res_cnt + CNT_W'(1);
        ns1 = next_slot_nxt + INDEX_WIDTH'(1);
        rc1 = run_code_nxt + 8'd1;
        next_slot_nxt = ns1;
        run_code_nxt  = rc1;
        if (rc1 == RUN_FULL) begin
          // 254 data bytes: backfill 0xFF and open a new run
          res[QIX_W'(res_cnt)] = make_res(1'b1, code_slot_nxt, rc1,
                                          1'b1, 1'b0, 1'b0, '0);
          res_cnt = res_cnt + CNT_W'(1);
          if (fits(ns1, cap_r)) begin
            code_slot_nxt = ns1;
            next_slot_nxt = ns1 + INDEX_WIDTH'(1);
            run_code_nxt  = 8'd1;
          end else begin
            failed_nxt = 1'b1;
          end
        end
      end
    end

    if (frame_done) begin
      if (failed_nxt) begin
        res[QIX_W'(res_cnt)] = make_res(1'b0, '0, 8'd0, 1'b0, 1'b1, 1'b1, '0);
      end else begin
        res[QIX_W'(res_cnt)] = make_res(1'b1, code_slot_nxt, run_code_nxt,
                                        1'b1, 1'b1, 1'b0, next_slot_nxt);
      end
      res_cnt       = res_cnt + CNT_W'(1);
      open_nxt      = 1'b0;
      failed_nxt    = 1'b0;
      code_slot_nxt = '0;
      next_slot_nxt = INDEX_WIDTH'(1);
      run_code_nxt  = 8'd1;
    end

    if (res_cnt != '0) begin
      res[QIX_W'(res_cnt - CNT_W'(1))].last_of_input = 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // State and configuration registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      code_slot_r <= '0;
      next_slot_r <= INDEX_WIDTH'(1);
      run_code_r  <= 8'd1;
      failed_r    <= 1'b0;
      open_r      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (in_fire) begin
        code_slot_r <= code_slot_nxt;
        next_slot_r <= next_slot_nxt;
        run_code_r  <= run_code_nxt;
        failed_r    <= failed_nxt;
        open_r      <= open_nxt;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result queue: loaded whole on accept, shifted toward the head on transfer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= '0;
    end else if (in_fire) begin
      q_cnt_r <= res_cnt;
    end else if (out_fire) begin
      q_cnt_r <= q_cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < MAX_RES; i++) begin
        q_r[i] <= res[i];
      end
    end else if (out_fire) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        q_r[i] <= q_r[i+1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // a frame closes after its final item
  a_frame_closes: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_data.empty_frame || in_data.last) |=> !open_r && !failed_r)
    else $error("frame still open after its final item");

  // the frame end result is always the final one of its item
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_end |-> out_data.last_of_input)
    else $error("frame end result not marked last of input");

  // a failed frame reports without a write
  a_error_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.error |-> out_data.frame_end && !out_data.write_valid)
    else $error("error result carries a write");

  // new items are taken only into an empty or draining queue
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> (q_cnt_r == '0) || (q_cnt_r == CNT_W'(1) && out_fire))
    else $error("result queue overrun");

endmodule
